/* design/selection_sort_by_key_core_macros.svh */
// assertion macros for the selection sort core checker
`ifndef SELECTION_SORT_BY_KEY_CORE_MACROS_SVH
`define SELECTION_SORT_BY_KEY_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SSK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication, disabled while reset is low
`define SSK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* design/ssk_pkg.sv */
// shared types and constants of the selection sort core
`timescale 1ns / 1ps
`default_nettype none

package ssk_pkg;

  localparam int unsigned KEY_W = 16;
  localparam int unsigned TAG_W = 8;
  localparam int unsigned REC_W = KEY_W + TAG_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_POS,
    ST_SORT_FIRST,
    ST_SORT_SCAN,
    ST_SWAP_BEST,
    ST_SWAP_POS,
    ST_EMIT_RD,
    ST_EMIT_LOAD,
    ST_EMIT_WAIT
  } state_e;

  typedef struct packed {
    logic store_item;  // write or drop the incoming request
    logic rd_pos;      // read entry at pos, start scan behind it
    logic take_first;  // load best and pos copies from read data
    logic rd_scan;     // read entry at scan index
    logic cmp_scan;    // compare read data against best
    logic wr_best;     // write pos copy to best index
    logic wr_pos;      // write best record to pos, advance pos
    logic rd_out;      // read entry at output index
    logic load_out;    // load output register
    logic next_out;    // advance output index
    logic clear_set;   // run done, empty the store
  } cmd_t;

  typedef struct packed {
    logic pos_last;   // no position left that needs a scan
    logic scan_more;  // scan index still below item count
    logic out_last;   // output index is the final record
  } sts_t;

endpackage

`default_nettype wire

/* design/selection_sort_by_key_core.sv */
// top level of the keyed record selection sort core
// load: one cycle per request while s_axis_tready is high; extra requests past MAX_ITEMS
//   are dropped and flagged on every result of the run
// sort: for each position, scan the records behind it for the smallest key, then swap; one read port
// emit: each result is read, registered and held until accepted, then the next one is read
// no new request is taken from the last input until the final result is accepted
// reset: asynchronous active low, store count and drop flag cleared, store contents left as is
`timescale 1ns / 1ps
`default_nettype none

module selection_sort_by_key_core #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input request stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [15:0] page_key, [23:16] record_tag
  input  wire logic        s_axis_tlast,   // last_in
  // sorted result stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [23:0] m_axis_tdata,   // [15:0] sorted_key, [23:16] sorted_tag
  output      logic        m_axis_tlast,   // last_out
  output      logic        m_axis_tuser    // overflow
);

  localparam int unsigned KW = ssk_pkg::KEY_W;
  localparam int unsigned RW = ssk_pkg::REC_W;

  ssk_pkg::cmd_t       cmd;
  ssk_pkg::sts_t       sts;
  logic [KW-1:0]       out_key;
  logic [ssk_pkg::TAG_W-1:0] out_tag;

  // sequencer: idle/load, per-position scan and swap, then one result at a time
  ssk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // store, running minimum with its index, and the output register
  ssk_dpath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_key_i   (s_axis_tdata[KW-1:0]),
    .in_tag_i   (s_axis_tdata[RW-1:KW]),
    .out_key_o  (out_key),
    .out_tag_o  (out_tag),
    .out_last_o (m_axis_tlast),
    .out_ovf_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {out_tag, out_key};

endmodule

`default_nettype wire

/* design/ssk_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ssk_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/ssk_dpath.sv */
// record store, sort indexes, best-record registers and output register
`timescale 1ns / 1ps
`default_nettype none

module ssk_dpath #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire ssk_pkg::cmd_t            cmd_i,
  output      ssk_pkg::sts_t            sts_o,
  input  wire logic [ssk_pkg::KEY_W-1:0] in_key_i,
  input  wire logic [ssk_pkg::TAG_W-1:0] in_tag_i,
  output      logic [ssk_pkg::KEY_W-1:0] out_key_o,
  output      logic [ssk_pkg::TAG_W-1:0] out_tag_o,
  output      logic                     out_last_o,
  output      logic                     out_ovf_o
);

  localparam int unsigned IW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned KW = ssk_pkg::KEY_W;
  localparam int unsigned RW = ssk_pkg::REC_W;

  logic [CW-1:0] count_q, count_d;
  logic          dropped_q, dropped_d;
  logic [IW-1:0] pos_q, pos_d;
  logic [CW-1:0] scan_q, scan_d;
  logic [IW-1:0] out_idx_q, out_idx_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [RW-1:0] best_rec_q, best_rec_d;
  logic [RW-1:0] pos_rec_q, pos_rec_d;
  logic [RW-1:0] out_rec_q, out_rec_d;
  logic          out_last_q, out_last_d;
  logic          out_ovf_q, out_ovf_d;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [RW-1:0] mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [RW-1:0] mem_rdata;
  logic          not_full;
  logic [CW-1:0] pos_next;
  logic [CW-1:0] out_next;

  ssk_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_ITEMS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign not_full = count_q < CW'(MAX_ITEMS);
  assign pos_next = CW'(pos_q) + CW'(1);
  assign out_next = CW'(out_idx_q) + CW'(1);

  assign sts_o.pos_last  = pos_next >= count_q;
  assign sts_o.scan_more = scan_q < count_q;
  assign sts_o.out_last  = out_next == count_q;

  // one write port: load, or one half of a swap
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_q[IW-1:0];
    mem_wdata = {in_tag_i, in_key_i};
    if (cmd_i.store_item && not_full) begin
      mem_we = 1'b1;
    end else if (cmd_i.wr_best) begin
      mem_we    = 1'b1;
      mem_waddr = best_idx_q;
      mem_wdata = pos_rec_q;
    end else if (cmd_i.wr_pos) begin
      mem_we    = 1'b1;
      mem_waddr = pos_q;
      mem_wdata = best_rec_q;
    end
  end

  always_comb begin
    mem_raddr = out_idx_q;
    if (cmd_i.rd_pos) begin
      mem_raddr = pos_q;
    end else if (cmd_i.rd_scan) begin
      mem_raddr = scan_q[IW-1:0];
    end else if (cmd_i.rd_out) begin
      mem_raddr = out_idx_q;
    end
  end

  always_comb begin
    count_d    = count_q;
    dropped_d  = dropped_q;
    pos_d      = pos_q;
    scan_d     = scan_q;
    out_idx_d  = out_idx_q;
    rd_idx_d   = rd_idx_q;
    best_idx_d = best_idx_q;
    best_rec_d = best_rec_q;
    pos_rec_d  = pos_rec_q;
    out_rec_d  = out_rec_q;
    out_last_d = out_last_q;
    out_ovf_d  = out_ovf_q;

    if (cmd_i.store_item) begin
      if (not_full) begin
        count_d = count_q + CW'(1);
      end else begin
        dropped_d = 1'b1;
      end
    end
    if (cmd_i.rd_pos) begin
      scan_d = pos_next;
    end
    if (cmd_i.take_first) begin
      best_rec_d = mem_rdata;
      pos_rec_d  = mem_rdata;
      best_idx_d = pos_q;
    end
    if (cmd_i.cmp_scan && (mem_rdata[KW-1:0] < best_rec_q[KW-1:0])) begin
      best_rec_d = mem_rdata;
      best_idx_d = rd_idx_q;
    end
    if (cmd_i.rd_scan) begin
      rd_idx_d = scan_q[IW-1:0];
      scan_d   = scan_q + CW'(1);
    end
    if (cmd_i.wr_pos) begin
      pos_d = pos_next[IW-1:0];
    end
    if (cmd_i.load_out) begin
      out_rec_d  = mem_rdata;
      out_last_d = sts_o.out_last;
      out_ovf_d  = dropped_q;
    end
    if (cmd_i.next_out) begin
      out_idx_d = out_next[IW-1:0];
    end
    if (cmd_i.clear_set) begin
      count_d   = '0;
      dropped_d = 1'b0;
      pos_d     = '0;
      out_idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      pos_q     <= '0;
      scan_q    <= '0;
      out_idx_q <= '0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
      pos_q     <= pos_d;
      scan_q    <= scan_d;
      out_idx_q <= out_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_rec_q <= best_rec_d;
    pos_rec_q  <= pos_rec_d;
    out_rec_q  <= out_rec_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_key_o  = out_rec_q[KW-1:0];
  assign out_tag_o  = out_rec_q[RW-1:KW];
  assign out_last_o = out_last_q;
  assign out_ovf_o  = out_ovf_q;

endmodule

`default_nettype wire

/* design/ssk_ctrl.sv */
// load, sort and emit sequencer of the selection sort core
`timescale 1ns / 1ps
`default_nettype none

module ssk_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_last_i,
  output      logic          in_ready_o,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  output      ssk_pkg::cmd_t cmd_o,
  input  wire ssk_pkg::sts_t sts_i
);

  ssk_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssk_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ssk_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.store_item = 1'b1;
          if (in_last_i) begin
            state_d = ssk_pkg::ST_SORT_POS;
          end
        end
      end
      ssk_pkg::ST_SORT_POS: begin
        if (sts_i.pos_last) begin
          state_d = ssk_pkg::ST_EMIT_RD;
        end else begin
          cmd_o.rd_pos = 1'b1;
          state_d      = ssk_pkg::ST_SORT_FIRST;
        end
      end
      ssk_pkg::ST_SORT_FIRST: begin
        cmd_o.take_first = 1'b1;
        cmd_o.rd_scan    = 1'b1;
        state_d          = ssk_pkg::ST_SORT_SCAN;
      end
      ssk_pkg::ST_SORT_SCAN: begin
        cmd_o.cmp_scan = 1'b1;
        if (sts_i.scan_more) begin
          cmd_o.rd_scan = 1'b1;
        end else begin
          state_d = ssk_pkg::ST_SWAP_BEST;
        end
      end
      ssk_pkg::ST_SWAP_BEST: begin
        cmd_o.wr_best = 1'b1;
        state_d       = ssk_pkg::ST_SWAP_POS;
      end
      ssk_pkg::ST_SWAP_POS: begin
        cmd_o.wr_pos = 1'b1;
        state_d      = ssk_pkg::ST_SORT_POS;
      end
      ssk_pkg::ST_EMIT_RD: begin
        cmd_o.rd_out = 1'b1;
        state_d      = ssk_pkg::ST_EMIT_LOAD;
      end
      ssk_pkg::ST_EMIT_LOAD: begin
        cmd_o.load_out = 1'b1;
        state_d        = ssk_pkg::ST_EMIT_WAIT;
      end
      ssk_pkg::ST_EMIT_WAIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.out_last) begin
            cmd_o.clear_set = 1'b1;
            state_d         = ssk_pkg::ST_IDLE;
          end else begin
            cmd_o.next_out = 1'b1;
            state_d        = ssk_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ssk_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/ssk_checker.sv */
// port-level checks of the selection sort core and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "selection_sort_by_key_core_macros.svh"

module ssk_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tuser
);

  logic        s_acc;
  logic        m_acc;
  logic        m_stall;
  logic [25:0] m_payload;

  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign m_acc     = m_axis_tvalid && m_axis_tready;
  assign m_stall   = m_axis_tvalid && !m_axis_tready;
  assign m_payload = {m_axis_tuser, m_axis_tlast, m_axis_tdata};

  // a stalled result holds its payload
  `SSK_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_stall, m_axis_tvalid && $stable(m_payload))

  // loading and emitting never overlap
  `SSK_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)

  // the last request of a set closes the input
  `SSK_ASSERT_NXT(a_last_closes, clk_i, rst_ni, s_acc && s_axis_tlast, !s_axis_tready)

  // each result is fetched from the store again after a handshake
  `SSK_ASSERT_NXT(a_out_gap, clk_i, rst_ni, m_acc, !m_axis_tvalid)

endmodule

bind selection_sort_by_key_core ssk_checker u_ssk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
